>>> sv/imf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types, constants and helpers of the frame mirror core.
// ----------------------------------------------------------------------------
package imf_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int PIXEL_W     = 24;
   localparam int DIM_W       = 7;
   localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int CMD_DEPTH   = 4;
   localparam int CPTR_W      = $clog2(CMD_DEPTH);
   localparam int CCNT_W      = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 2);

   localparam int CSR_IDX_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_MIRROR_H     = 2'd2,
      CSR_MIRROR_V     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_FETCH     = 2'd1,
      CMD_NOT_READY = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic               func;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               frame_end;
      logic               ready_res;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } cmd_type;

   // 0 acts as 1, anything above the maximum acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > maxv) r = maxv;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/imf_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imf_cmd_fifo
// Short command queue between the front (counters) and back (frame store).
// ----------------------------------------------------------------------------
module imf_cmd_fifo (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  imf_pkg::cmd_type  push_data,
   output logic              full,
   input  wire               pop,
   output logic              valid,
   output imf_pkg::cmd_type  pop_data
);

   imf_pkg::cmd_type entry_ff [imf_pkg::CMD_DEPTH];
   logic [imf_pkg::CPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [imf_pkg::CPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [imf_pkg::CCNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full     = (cnt_ff == imf_pkg::CCNT_W'(imf_pkg::CMD_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + imf_pkg::CPTR_W'(1);
      if (do_pop)  rd_ptr_in = rd_ptr_ff + imf_pkg::CPTR_W'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + imf_pkg::CCNT_W'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - imf_pkg::CCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

>>> sv/imf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imf_front
// Register file, load/output position counters and word classification.
// Turns each accepted word into a store command with its address.
// ----------------------------------------------------------------------------
module imf_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   input  imf_pkg::req_type               req_data,
   output logic                           req_full,
   input  wire                            csr_we,
   input  wire [imf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [imf_pkg::DIM_W-1:0]       csr_wdata,
   input  wire                            cmd_full,
   output logic                           cmd_push,
   output imf_pkg::cmd_type               cmd_data
);

   localparam int DW = imf_pkg::DIM_W;
   localparam int RW = imf_pkg::ROW_W;
   localparam int CW = imf_pkg::COL_W;
   localparam int AW = imf_pkg::ADDR_W;

   logic [DW-1:0] width_ff, width_in, height_ff, height_in;
   logic          mirror_h_ff, mirror_h_in, mirror_v_ff, mirror_v_in;
   logic [RW-1:0] load_row_ff, load_row_in, out_row_ff, out_row_in;
   logic [CW-1:0] load_col_ff, load_col_in, out_col_ff, out_col_in;
   logic          full_ff, full_in;

   logic [DW-1:0] w, h;
   logic [RW-1:0] row, src_row;
   logic [CW-1:0] col, src_col;
   logic          accept;

   assign w        = imf_pkg::clamp_dim(width_ff, DW'(imf_pkg::MAX_WIDTH));
   assign h        = imf_pkg::clamp_dim(height_ff, DW'(imf_pkg::MAX_HEIGHT));
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      mirror_h_in = mirror_h_ff;
      mirror_v_in = mirror_v_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      full_in     = full_ff;
      row         = '0;
      col         = '0;
      src_row     = '0;
      src_col     = '0;
      cmd_push    = accept;
      cmd_data.kind  = imf_pkg::CMD_NOT_READY;
      cmd_data.addr  = '0;
      cmd_data.pixel = req_data.pixel_in;
      cmd_data.last  = 1'b0;

      if (accept && !req_data.func) begin
         cmd_data.kind = imf_pkg::CMD_LOAD;
         row = load_row_ff;
         col = load_col_ff;
         if (full_ff) begin
            // new frame: everything restarts
            row        = '0;
            col        = '0;
            out_row_in = '0;
            out_col_in = '0;
            full_in    = 1'b0;
         end
         if (DW'(row) >= h || DW'(col) >= w) begin
            row = '0;
            col = '0;
         end
         cmd_data.addr = AW'(row) * AW'(imf_pkg::MAX_WIDTH) + AW'(col);
         load_row_in = row;
         load_col_in = col + CW'(1);
         if (DW'(col) + DW'(1) >= w) begin
            load_col_in = '0;
            load_row_in = row + RW'(1);
            if (DW'(row) + DW'(1) >= h) begin
               load_row_in = '0;
               full_in     = 1'b1;
               out_row_in  = '0;
               out_col_in  = '0;
            end
         end
      end else if (accept && full_ff) begin
         cmd_data.kind = imf_pkg::CMD_FETCH;
         row = out_row_ff;
         col = out_col_ff;
         if (DW'(row) >= h || DW'(col) >= w) begin
            row = '0;
            col = '0;
         end
         src_row = mirror_v_ff ? RW'(h - DW'(1) - DW'(row)) : row;
         src_col = mirror_h_ff ? CW'(w - DW'(1) - DW'(col)) : col;
         cmd_data.addr = AW'(src_row) * AW'(imf_pkg::MAX_WIDTH) + AW'(src_col);
         cmd_data.last = (DW'(row) == h - DW'(1)) && (DW'(col) == w - DW'(1));
         out_row_in = row;
         out_col_in = col + CW'(1);
         if (DW'(col) + DW'(1) >= w) begin
            out_col_in = '0;
            out_row_in = row + RW'(1);
            if (DW'(row) + DW'(1) >= h) out_row_in = '0;
         end
      end

      if (csr_we) begin
         unique case (imf_pkg::csr_index_type'(csr_index)) inside
            imf_pkg::CSR_FRAME_WIDTH, imf_pkg::CSR_FRAME_HEIGHT: begin
               if (imf_pkg::csr_index_type'(csr_index) == imf_pkg::CSR_FRAME_WIDTH)
                  width_in = csr_wdata;
               else
                  height_in = csr_wdata;
               load_row_in = '0;
               load_col_in = '0;
               out_row_in  = '0;
               out_col_in  = '0;
               full_in     = 1'b0;
            end
            imf_pkg::CSR_MIRROR_H: mirror_h_in = csr_wdata[0];
            imf_pkg::CSR_MIRROR_V: mirror_v_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DW'(imf_pkg::MAX_WIDTH);
         height_ff   <= DW'(imf_pkg::MAX_HEIGHT);
         mirror_h_ff <= 1'b0;
         mirror_v_ff <= 1'b0;
         load_row_ff <= '0;
         load_col_ff <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         full_ff     <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         mirror_h_ff <= mirror_h_in;
         mirror_v_ff <= mirror_v_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         full_ff     <= full_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/imf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imf_back
// Frame store, registered read stage and result queue. Commands are
// executed strictly in order, one store access per cycle if results have room.
// ----------------------------------------------------------------------------
module imf_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   input  imf_pkg::cmd_type  cmd_data,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   output imf_pkg::rsp_type  rsp_data
);

   localparam int OW = imf_pkg::OCNT_W;
   localparam int PW = imf_pkg::OPTR_W;

   logic [imf_pkg::PIXEL_W-1:0] store_mem [imf_pkg::STORE_DEPTH];
   logic [imf_pkg::PIXEL_W-1:0] rd_pixel_ff;
   logic st_valid_ff, st_valid_in;
   logic st_ready_ff, st_last_ff;

   imf_pkg::rsp_type out_q_ff [imf_pkg::OUT_DEPTH];
   imf_pkg::rsp_type push_word;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic room, is_load, do_pop;

   // a result slot is reserved before the store is read
   assign room    = (cnt_ff + OW'(st_valid_ff)) < OW'(imf_pkg::OUT_DEPTH);
   assign is_load = (cmd_data.kind == imf_pkg::CMD_LOAD);
   assign cmd_pop = cmd_valid && (is_load || room);
   assign st_valid_in = cmd_pop && !is_load;

   assign push_word.pixel_out = st_ready_ff ? rd_pixel_ff : '0;
   assign push_word.frame_end = st_last_ff;
   assign push_word.ready_res = st_ready_ff;

   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data  = out_q_ff[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (cmd_pop && is_load) store_mem[cmd_data.addr] <= cmd_data.pixel;
      if (cmd_pop && cmd_data.kind == imf_pkg::CMD_FETCH)
         rd_pixel_ff <= store_mem[cmd_data.addr];
   end

   always_ff @(posedge clock) begin
      st_ready_ff <= (cmd_data.kind == imf_pkg::CMD_FETCH);
      st_last_ff  <= cmd_data.last;
      if (st_valid_ff) out_q_ff[wr_ptr_ff] <= push_word;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (st_valid_ff) wr_ptr_in = wr_ptr_ff + PW'(1);
      if (do_pop)      rd_ptr_in = rd_ptr_ff + PW'(1);
      if (st_valid_ff && !do_pop) cnt_in = cnt_ff + OW'(1);
      else if (!st_valid_ff && do_pop) cnt_in = cnt_ff - OW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         st_valid_ff <= st_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/image_mirror_flip_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_mirror_flip_core
// Frame mirror: loads a frame in raster order, returns it flipped.
// ----------------------------------------------------------------------------
// Push load words (func 0) in raster order; once the whole frame is in,
// each fetch word (func 1) returns the next pixel of the mirrored frame,
// with frame_end on its last pixel; fetches before the frame is complete
// return ready_res 0 and pixel zero. Loads return nothing. One word is taken
// per clock while req_full is low, set by the single-port frame store that
// each word uses at most once; a fetch result passes the command queue, read
// stage and result queue to the rsp side. Writing frame_width or frame_height
// drops the frame in progress; the store needs no clearing after reset.
module image_mirror_flip_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   input  imf_pkg::req_type               req_data,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output imf_pkg::rsp_type               rsp_data,
   input  wire                            csr_we,
   input  wire [imf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [imf_pkg::DIM_W-1:0]       csr_wdata
);

   logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
   imf_pkg::cmd_type cmd_in_data, cmd_out_data;

   imf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data)
   );

   imf_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .pop_data  (cmd_out_data)
   );

   imf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame mirror core. Frames of random size are
// loaded, then read back with random horizontal and vertical flips; a
// scoreboard mirrors the frame store and checks each returned word.
// ----------------------------------------------------------------------------
import imf_pkg::*;

typedef enum logic {
   FUNC_LOAD  = 1'b0,
   FUNC_FETCH = 1'b1
} func_code_type;

class mirror_scoreboard;
   logic [PIXEL_W-1:0] frame_mem [STORE_DEPTH];
   int unsigned        ld_row, ld_col, rd_row, rd_col;
   bit                 frame_ready;
   logic [DIM_W-1:0]   width_reg, height_reg;
   bit                 flip_h, flip_v;
   rsp_type            pending_pixels[$];
   int                 errors;

   function new();
      foreach (frame_mem[i]) frame_mem[i] = '0;
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      flip_h     = 1'b0;
      flip_v     = 1'b0;
      errors     = 0;
      restart();
   endfunction

   function void restart();
      ld_row      = 0;
      ld_col      = 0;
      rd_row      = 0;
      rd_col      = 0;
      frame_ready = 1'b0;
   endfunction

   // 0 behaves as 1, values past the maximum behave as the maximum
   function int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function int unsigned frame_pixels();
      return usable_dim(width_reg, MAX_WIDTH) * usable_dim(height_reg, MAX_HEIGHT);
   endfunction

   function void write_reg(csr_index_type idx, logic [DIM_W-1:0] v);
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = v;
            restart();
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = v;
            restart();
         end
         CSR_MIRROR_H: flip_h = v[0];
         CSR_MIRROR_V: flip_v = v[0];
         default: ;
      endcase
   endfunction

   function void accept_word(req_type w);
      int unsigned wd, ht, r, c;
      rsp_type     want;
      wd = usable_dim(width_reg, MAX_WIDTH);
      ht = usable_dim(height_reg, MAX_HEIGHT);
      want = '0;
      if (w.func == FUNC_LOAD) begin
         if (frame_ready) restart();
         if (ld_row >= ht || ld_col >= wd) begin
            ld_row = 0;
            ld_col = 0;
         end
         frame_mem[ld_row * MAX_WIDTH + ld_col] = w.pixel_in;
         ld_col++;
         if (ld_col >= wd) begin
            ld_col = 0;
            ld_row++;
            if (ld_row >= ht) begin
               ld_row      = 0;
               frame_ready = 1'b1;
               rd_row      = 0;
               rd_col      = 0;
            end
         end
         return;
      end
      if (!frame_ready) begin
         pending_pixels.push_back(want);
         return;
      end
      if (rd_row >= ht || rd_col >= wd) begin
         rd_row = 0;
         rd_col = 0;
      end
      r = flip_v ? ht - 1 - rd_row : rd_row;
      c = flip_h ? wd - 1 - rd_col : rd_col;
      want.pixel_out = frame_mem[r * MAX_WIDTH + c];
      want.frame_end = (rd_row == ht - 1) && (rd_col == wd - 1);
      want.ready_res = 1'b1;
      rd_col++;
      if (rd_col >= wd) begin
         rd_col = 0;
         rd_row++;
         if (rd_row >= ht) rd_row = 0;
      end
      pending_pixels.push_back(want);
   endfunction

   task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (pending_pixels.size() == 0) begin
         report($sformatf("unexpected word %h", got));
         return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out)
         report($sformatf("pixel_out %h, want %h", got.pixel_out, want.pixel_out));
      if (got.frame_end !== want.frame_end)
         report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
      if (got.ready_res !== want.ready_res)
         report($sformatf("ready_res %b, want %b", got.ready_res, want.ready_res));
   endtask

   task final_check();
      if (pending_pixels.size() != 0)
         report($sformatf("%0d words never arrived", pending_pixels.size()));
   endtask
endclass

module tb_top;

   localparam int ITEM_TARGET  = 1200;
   localparam int DRAIN_CYCLES = 16;
   localparam int QUIET_LIMIT  = 20000;

   logic             clock;
   logic             reset;
   logic             req_push;
   req_type          req_data;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   rsp_type          rsp_data;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [DIM_W-1:0] csr_wdata;

   mirror_scoreboard sb;
   bit               idle_on;
   int               word_count;
   int               stall_left;

   image_mirror_flip_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return PIXEL_W'($urandom);
   endfunction

   function automatic logic [DIM_W-1:0] random_dim();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) return DIM_W'($urandom_range(1, 4));
      if (sel < 15) return DIM_W'($urandom_range(5, 12));
      case (sel)
         15: return '0;
         16: return DIM_W'(1);
         17: return DIM_W'(MAX_WIDTH);
         18: return DIM_W'($urandom_range(MAX_WIDTH + 1, 127));
         default: return DIM_W'(MAX_WIDTH - 1);
      endcase
   endfunction

   // all drive tasks start and end right after a falling edge
   task automatic send_word(input func_code_type f, input logic [PIXEL_W-1:0] pix);
      req_type w;
      int      gap;
      w.func     = f;
      w.pixel_in = pix;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      sb.accept_word(w);
      word_count++;
      @(negedge clock);
   endtask

   // loads leave no result behind, so allow the pipe to drain after the last one
   task automatic wait_quiet();
      int guard;
      req_push <= 1'b0;
      guard = 0;
      while (sb.pending_pixels.size() != 0 && guard < QUIET_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [DIM_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic write_regs(input bit en_w, input logic [DIM_W-1:0] w,
                             input bit en_h, input logic [DIM_W-1:0] h,
                             input bit en_mh, input bit mh,
                             input bit en_mv, input bit mv);
      if (en_w) put_csr(CSR_FRAME_WIDTH, w);
      if (en_h) put_csr(CSR_FRAME_HEIGHT, h);
      if (en_mh) put_csr(CSR_MIRROR_H, DIM_W'(mh));
      if (en_mv) put_csr(CSR_MIRROR_V, DIM_W'(mv));
      csr_we <= 1'b0;
   endtask

   // result side: random stall bursts while idle_on is set
   initial begin
      rsp_pop    = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [DIM_W-1:0] w, h;
      bit               en_dims;
      int unsigned      n, style;
      sb         = new();
      idle_on    = 1'b1;
      word_count = 0;
      reset      = 1'b1;
      req_push   = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fetch before any frame is in
      send_word(FUNC_FETCH, '1);

      // 2x2 with both flips, read past the end to wrap
      wait_quiet();
      write_regs(1, DIM_W'(2), 1, DIM_W'(2), 1, 1, 1, 1);
      send_word(FUNC_LOAD, 24'h000000);
      send_word(FUNC_LOAD, 24'hFFFFFF);
      send_word(FUNC_LOAD, 24'h123456);
      send_word(FUNC_LOAD, 24'hA5C3F0);
      repeat (5) send_word(FUNC_FETCH, 24'h000000);

      // mirror change mid-frame keeps the read position
      wait_quiet();
      write_regs(0, '0, 0, '0, 1, 0, 0, 0);
      repeat (2) send_word(FUNC_FETCH, 24'h5A5A5A);

      // load on a full frame starts over
      send_word(FUNC_LOAD, 24'h0F0F0F);
      send_word(FUNC_FETCH, 24'h000000);

      // width write drops the partial frame
      wait_quiet();
      write_regs(1, DIM_W'(3), 0, '0, 0, 0, 0, 0);
      send_word(FUNC_LOAD, 24'h800001);
      send_word(FUNC_LOAD, 24'h7FFFFE);
      send_word(FUNC_FETCH, 24'hFFFFFF);

      // zero width acts as a single column
      wait_quiet();
      write_regs(1, '0, 1, DIM_W'(1), 1, 1, 1, 0);
      send_word(FUNC_LOAD, 24'hC0FFEE);
      repeat (2) send_word(FUNC_FETCH, 24'h000000);

      while (word_count < ITEM_TARGET) begin
         idle_on = (word_count < ITEM_TARGET * 85 / 100) && ($urandom_range(0, 3) != 0);
         wait_quiet();
         en_dims = ($urandom_range(0, 9) < 6);
         w = random_dim();
         h = random_dim();
         if (sb.usable_dim(w, MAX_WIDTH) * sb.usable_dim(h, MAX_HEIGHT) > 128)
            h = DIM_W'($urandom_range(1, 2));
         write_regs(en_dims, w, en_dims, h,
                    $urandom_range(0, 9) < 7, $urandom_range(0, 1),
                    $urandom_range(0, 9) < 7, $urandom_range(0, 1));
         n = sb.frame_pixels();
         style = $urandom_range(0, 19);
         if (style < 14) begin
            repeat (n) send_word(FUNC_LOAD, random_pixel());
            repeat ($urandom_range(1, 2 * n + 1)) send_word(FUNC_FETCH, random_pixel());
         end else if (style < 16) begin
            repeat ($urandom_range(0, n - 1)) send_word(FUNC_LOAD, random_pixel());
            repeat ($urandom_range(1, 3)) send_word(FUNC_FETCH, random_pixel());
         end else if (style < 18) begin
            repeat ($urandom_range(1, n + 2)) send_word(FUNC_FETCH, random_pixel());
         end else begin
            repeat ($urandom_range(1, 20))
               send_word(func_code_type'($urandom_range(0, 1)), random_pixel());
         end
      end

      wait_quiet();
      sb.final_check();
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
